>>> rtl/core/atfb_pkg.sv
package atfb_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned IdxW   = 5;

  // result positions within one item's run
  localparam logic [IdxW-1:0] IdxHdrFirst = 5'd0;
  localparam logic [IdxW-1:0] IdxSumStart = 5'd3;
  localparam logic [IdxW-1:0] IdxHdrLast  = 5'd16;
  localparam logic [IdxW-1:0] IdxData     = 5'd17;
  localparam logic [IdxW-1:0] IdxChk      = 5'd18;

  localparam logic [DataW-1:0] StartDelim  = 8'h7E;
  localparam logic [DataW-1:0] LenHigh     = 8'h00;
  localparam logic [DataW-1:0] FrameTypeTx = 8'h10;
  localparam logic [DataW-1:0] LenOverhead = 8'd14;
  localparam logic [DataW-1:0] MinPayload  = 8'd1;
  localparam logic [DataW-1:0] MaxPayload  = 8'd241;
  localparam logic [DataW-1:0] ChkBase     = 8'hFF;

  localparam logic [31:0] DestHighRst = 32'h0013A200;
  localparam logic [31:0] DestLowRst  = 32'h42010905;
  localparam logic [15:0] NetAddrRst  = 16'hFFFE;
  localparam logic [7:0]  FrameIdRst  = 8'h01;
  localparam logic [7:0]  RadiusRst   = 8'h00;
  localparam logic [7:0]  OptionsRst  = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEST_HIGH = 3'd0,
    CFG_DEST_LOW  = 3'd1,
    CFG_NET_ADDR  = 3'd2,
    CFG_FRAME_ID  = 3'd3,
    CFG_RADIUS    = 3'd4,
    CFG_OPTIONS   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] dest_addr_high;
    logic [31:0] dest_addr_low;
    logic [15:0] network_addr;
    logic [7:0]  frame_id;
    logic [7:0]  hop_radius;
    logic [7:0]  tx_options;
  } cfg_t;

  typedef struct packed {
    logic [DataW-1:0] out_byte;
    logic             last_of_run;
    logic             frame_end;
  } res_t;

  function automatic logic [DataW-1:0] hdr_byte(input logic [IdxW-1:0] idx,
                                                input cfg_t cfg,
                                                input logic [DataW-1:0] len);
    logic [DataW-1:0] b;
    case (idx)
      5'd0:    b = StartDelim;
      5'd1:    b = LenHigh;
      5'd2:    b = len + LenOverhead;
      5'd3:    b = FrameTypeTx;
      5'd4:    b = cfg.frame_id;
      5'd5:    b = cfg.dest_addr_high[31:24];
      5'd6:    b = cfg.dest_addr_high[23:16];
      5'd7:    b = cfg.dest_addr_high[15:8];
      5'd8:    b = cfg.dest_addr_high[7:0];
      5'd9:    b = cfg.dest_addr_low[31:24];
      5'd10:   b = cfg.dest_addr_low[23:16];
      5'd11:   b = cfg.dest_addr_low[15:8];
      5'd12:   b = cfg.dest_addr_low[7:0];
      5'd13:   b = cfg.network_addr[15:8];
      5'd14:   b = cfg.network_addr[7:0];
      5'd15:   b = cfg.hop_radius;
      5'd16:   b = cfg.tx_options;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/atfb_if.sv
interface atfb_in_if;
  logic                         valid;
  logic                         ready;
  logic [atfb_pkg::DataW-1:0]   data_byte;
  logic [atfb_pkg::DataW-1:0]   payload_len;

  modport source (output valid, output data_byte, output payload_len, input ready);
  modport sink   (input valid, input data_byte, input payload_len, output ready);
endinterface

interface atfb_out_if;
  logic                         valid;
  logic                         ready;
  logic [atfb_pkg::DataW-1:0]   out_byte;
  logic                         last_of_run;
  logic                         frame_end;

  modport source (output valid, output out_byte, output last_of_run, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input frame_end,
                  output ready);
endinterface

>>> rtl/core/atfb_cfg_regs.sv
module atfb_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [atfb_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [atfb_pkg::CfgW-1:0]       cfg_wdata,
  output atfb_pkg::cfg_t                  cfg
);

  atfb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_addr_high <= atfb_pkg::DestHighRst;
      cfg_r.dest_addr_low  <= atfb_pkg::DestLowRst;
      cfg_r.network_addr   <= atfb_pkg::NetAddrRst;
      cfg_r.frame_id       <= atfb_pkg::FrameIdRst;
      cfg_r.hop_radius     <= atfb_pkg::RadiusRst;
      cfg_r.tx_options     <= atfb_pkg::OptionsRst;
    end else if (cfg_we) begin
      case (atfb_pkg::cfg_idx_t'(cfg_idx))
        atfb_pkg::CFG_DEST_HIGH: cfg_r.dest_addr_high <= cfg_wdata;
        atfb_pkg::CFG_DEST_LOW:  cfg_r.dest_addr_low  <= cfg_wdata;
        atfb_pkg::CFG_NET_ADDR:  cfg_r.network_addr   <= cfg_wdata[15:0];
        atfb_pkg::CFG_FRAME_ID:  cfg_r.frame_id       <= cfg_wdata[7:0];
        atfb_pkg::CFG_RADIUS:    cfg_r.hop_radius     <= cfg_wdata[7:0];
        atfb_pkg::CFG_OPTIONS:   cfg_r.tx_options     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/atfb_seq.sv
module atfb_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [atfb_pkg::DataW-1:0]    in_data,
  input  logic [atfb_pkg::DataW-1:0]    in_len,
  output logic                          in_ready,
  input  atfb_pkg::cfg_t                cfg,
  input  logic                          emit_en,
  output logic                          emit,
  output atfb_pkg::res_t                res
);

  logic                        work_v_r, work_v_nxt;
  logic [atfb_pkg::DataW-1:0]  work_data_r;
  logic [atfb_pkg::DataW-1:0]  work_len_r;
  logic                        work_end_r;
  logic [atfb_pkg::IdxW-1:0]   idx_r, idx_nxt;
  logic [atfb_pkg::DataW-1:0]  bl_r, bl_nxt;
  logic [atfb_pkg::DataW-1:0]  sum_r, sum_nxt;

  logic                        accept;
  logic                        first;
  logic [atfb_pkg::DataW-1:0]  len_clamped;
  logic [atfb_pkg::DataW-1:0]  bl_dec;
  logic [atfb_pkg::DataW-1:0]  hdr_b;
  logic                        is_last;

  assign hdr_b   = atfb_pkg::hdr_byte(idx_r, cfg, work_len_r);
  assign is_last = (idx_r == atfb_pkg::IdxChk) || (idx_r == atfb_pkg::IdxData && !work_end_r);
  assign emit    = work_v_r && emit_en;
  assign in_ready = !work_v_r || (emit && is_last);
  assign accept  = in_valid && in_ready;

  // frame start is decided when the transaction enters
  assign first = (bl_r == '0);

  always_comb begin
    if (in_len < atfb_pkg::MinPayload) begin
      len_clamped = atfb_pkg::MinPayload;
    end else if (in_len > atfb_pkg::MaxPayload) begin
      len_clamped = atfb_pkg::MaxPayload;
    end else begin
      len_clamped = in_len;
    end
  end

  assign bl_dec = (first ? len_clamped : bl_r) - 8'd1;

  always_comb begin
    res.last_of_run = is_last;
    res.frame_end   = (idx_r == atfb_pkg::IdxChk);
    if (idx_r == atfb_pkg::IdxChk) begin
      res.out_byte = atfb_pkg::ChkBase - sum_r;
    end else if (idx_r == atfb_pkg::IdxData) begin
      res.out_byte = work_data_r;
    end else begin
      res.out_byte = hdr_b;
    end
  end

  always_comb begin
    sum_nxt    = sum_r;
    idx_nxt    = idx_r;
    work_v_nxt = work_v_r;
    bl_nxt     = bl_r;
    if (emit) begin
      if (idx_r == atfb_pkg::IdxChk) begin
        sum_nxt = '0;
      end else if (idx_r == atfb_pkg::IdxData) begin
        sum_nxt = sum_r + work_data_r;
      end else if (idx_r >= atfb_pkg::IdxSumStart && idx_r <= atfb_pkg::IdxHdrLast) begin
        sum_nxt = sum_r + hdr_b;
      end
      if (is_last) begin
        work_v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 5'd1;
      end
    end
    if (accept) begin
      work_v_nxt = 1'b1;
      idx_nxt    = first ? atfb_pkg::IdxHdrFirst : atfb_pkg::IdxData;
      bl_nxt     = bl_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_v_r <= 1'b0;
      idx_r    <= '0;
      bl_r     <= '0;
      sum_r    <= '0;
    end else begin
      work_v_r <= work_v_nxt;
      idx_r    <= idx_nxt;
      bl_r     <= bl_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      work_data_r <= in_data;
      work_len_r  <= len_clamped;
      work_end_r  <= (bl_dec == '0);
    end
  end

endmodule

>>> rtl/core/api_transmit_frame_builder.sv
// Wraps a payload byte stream into API transmit-request frames. The first payload
// byte of a frame (payload_len sampled there, clamped to 1..241) produces the
// 17-byte header followed by that byte; later bytes pass through, and the frame's
// final byte is followed by the checksum, flagged with frame_end. last_of_run marks
// the final output byte caused by each input transaction. Output is one byte per
// cycle when out_ch.ready allows, from a single result register; a middle byte frees
// the input as it goes out, so one transaction per cycle is sustained; a first byte
// holds it until the header and the byte are out, a final byte until the checksum.
// Destination, network address, frame id, radius and options are read as the header
// goes out, so the user must write configuration between frames; it is not enforced.
module api_transmit_frame_builder (
  input  logic                          clk,
  input  logic                          rst_n,
  atfb_in_if.sink                       in_ch,
  atfb_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [atfb_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [atfb_pkg::CfgW-1:0]     cfg_wdata
);

  atfb_pkg::cfg_t cfg;
  atfb_pkg::res_t res;
  atfb_pkg::res_t out_res_r;
  logic           out_v_r, out_v_nxt;
  logic           emit_en;
  logic           emit;

  atfb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  atfb_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_data  (in_ch.data_byte),
    .in_len   (in_ch.payload_len),
    .in_ready (in_ch.ready),
    .cfg      (cfg),
    .emit_en  (emit_en),
    .emit     (emit),
    .res      (res)
  );

  assign emit_en = !out_v_r || out_ch.ready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.out_byte    = out_res_r.out_byte;
  assign out_ch.last_of_run = out_res_r.last_of_run;
  assign out_ch.frame_end   = out_res_r.frame_end;

endmodule

>>> sim/tb_top.sv
module tb_top;
  import atfb_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;
  localparam int HdrBytes   = 17;
  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 240;
  localparam int PlanLen    = 26;

  typedef enum {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    wval;
    logic [DataW-1:0]   data;
    logic [DataW-1:0]   len;
    bit                 chk_known;
    logic [DataW-1:0]   chk;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_wdata;

  atfb_in_if  in_ch();
  atfb_out_if out_ch();

  api_transmit_frame_builder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // frame builder prediction state
  cfg_t             reg_shadow;
  logic [DataW-1:0] pay_left;
  logic [DataW-1:0] chk_acc;
  res_t             frame_bytes_q[$];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  hold_rx = 1'b0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  step_row_t plan [PlanLen];

  function automatic void push_byte(input logic [DataW-1:0] b, input logic last,
                                    input logic fend);
    res_t r;
    r.out_byte    = b;
    r.last_of_run = last;
    r.frame_end   = fend;
    frame_bytes_q.push_back(r);
  endfunction

  function automatic void predict_frame_bytes(input logic [DataW-1:0] d,
                                              input logic [DataW-1:0] l);
    logic [DataW-1:0] hdr [HdrBytes];
    logic [DataW-1:0] n;
    if (pay_left == '0) begin
      n = l;
      if (n < MinPayload) n = MinPayload;
      if (n > MaxPayload) n = MaxPayload;
      hdr = '{StartDelim, LenHigh, n + LenOverhead, FrameTypeTx, reg_shadow.frame_id,
              reg_shadow.dest_addr_high[31:24], reg_shadow.dest_addr_high[23:16],
              reg_shadow.dest_addr_high[15:8], reg_shadow.dest_addr_high[7:0],
              reg_shadow.dest_addr_low[31:24], reg_shadow.dest_addr_low[23:16],
              reg_shadow.dest_addr_low[15:8], reg_shadow.dest_addr_low[7:0],
              reg_shadow.network_addr[15:8], reg_shadow.network_addr[7:0],
              reg_shadow.hop_radius, reg_shadow.tx_options};
      chk_acc = '0;
      for (int i = 0; i < HdrBytes; i++) begin
        push_byte(hdr[i], 1'b0, 1'b0);
        // checksum covers frame type onward
        if (i >= int'(IdxSumStart)) chk_acc = chk_acc + hdr[i];
      end
      pay_left = n;
    end
    chk_acc  = chk_acc + d;
    pay_left = pay_left - 1'b1;
    if (pay_left == '0) begin
      push_byte(d, 1'b0, 1'b0);
      push_byte(ChkBase - chk_acc, 1'b1, 1'b1);
      chk_acc = '0;
    end else begin
      push_byte(d, 1'b1, 1'b0);
    end
  endfunction

  task automatic send_item(input logic [DataW-1:0] d, input logic [DataW-1:0] l);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= d;
    in_ch.payload_len <= l;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame_bytes(d, l);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DEST_HIGH: reg_shadow.dest_addr_high = v;
      CFG_DEST_LOW:  reg_shadow.dest_addr_low  = v;
      CFG_NET_ADDR:  reg_shadow.network_addr   = v[15:0];
      CFG_FRAME_ID:  reg_shadow.frame_id       = v[7:0];
      CFG_RADIUS:    reg_shadow.hop_radius     = v[7:0];
      CFG_OPTIONS:   reg_shadow.tx_options     = v[7:0];
      default: ;
    endcase
  endtask

  initial begin : stimulus
    res_t r;
    logic [DataW-1:0] l;
    int sent;
    plan = '{
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'h00, 8'd1,   1'b1, 8'hEB},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'hFF, 8'd1,   1'b1, 8'hEC},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'hA5, 8'd0,   1'b1, 8'h46},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'h01, 8'd3,   1'b0, 8'h00},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'h80, 8'hFF,  1'b0, 8'h00},
      '{ROW_WRITE, CFG_FRAME_ID,  32'hFF, 8'h00, 8'd0,  1'b0, 8'h00},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'h7F, 8'd0,   1'b0, 8'h00},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'h5A, 8'd2,   1'b0, 8'h00},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'hC3, 8'd1,   1'b0, 8'h00},
      '{ROW_WRITE, CfgIdxSpareLo, 32'hFFFF_FFFF, 8'h00, 8'd0, 1'b0, 8'h00},
      '{ROW_WRITE, CfgIdxSpareHi, 32'h0, 8'h00, 8'd0,   1'b0, 8'h00},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'h3C, 8'd1,   1'b0, 8'h00},
      '{ROW_WRITE, CFG_DEST_HIGH, 32'hFFFF_FFFF, 8'h00, 8'd0, 1'b0, 8'h00},
      '{ROW_WRITE, CFG_DEST_LOW,  32'hFFFF_FFFF, 8'h00, 8'd0, 1'b0, 8'h00},
      '{ROW_WRITE, CFG_NET_ADDR,  32'h0000_FFFF, 8'h00, 8'd0, 1'b0, 8'h00},
      '{ROW_WRITE, CFG_FRAME_ID,  32'hFF, 8'h00, 8'd0,  1'b0, 8'h00},
      '{ROW_WRITE, CFG_RADIUS,    32'hFF, 8'h00, 8'd0,  1'b0, 8'h00},
      '{ROW_WRITE, CFG_OPTIONS,   32'hFF, 8'h00, 8'd0,  1'b0, 8'h00},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'hFF, 8'd1,   1'b1, 8'hFD},
      '{ROW_WRITE, CFG_DEST_HIGH, 32'h0, 8'h00, 8'd0,   1'b0, 8'h00},
      '{ROW_WRITE, CFG_DEST_LOW,  32'h0, 8'h00, 8'd0,   1'b0, 8'h00},
      '{ROW_WRITE, CFG_NET_ADDR,  32'h0, 8'h00, 8'd0,   1'b0, 8'h00},
      '{ROW_WRITE, CFG_FRAME_ID,  32'h0, 8'h00, 8'd0,   1'b0, 8'h00},
      '{ROW_WRITE, CFG_RADIUS,    32'h0, 8'h00, 8'd0,   1'b0, 8'h00},
      '{ROW_WRITE, CFG_OPTIONS,   32'h0, 8'h00, 8'd0,   1'b0, 8'h00},
      '{ROW_ITEM,  CFG_DEST_HIGH, 32'h0, 8'h00, 8'd1,   1'b1, 8'hEF}
    };

    reg_shadow = '{DestHighRst, DestLowRst, NetAddrRst, FrameIdRst, RadiusRst, OptionsRst};
    pay_left = '0;
    chk_acc  = '0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.payload_len <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_wdata         <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        drain_results();
        write_reg(plan[k].idx, plan[k].wval);
      end else begin
        send_item(plan[k].data, plan[k].len);
        // hand-computed checksum replaces the predicted one
        if (plan[k].chk_known) begin
          r = frame_bytes_q.pop_back();
          r.out_byte = plan[k].chk;
          frame_bytes_q.push_back(r);
        end
      end
    end

    // a mid-length frame, with the result side held off so the input backs up
    drain_results();
    hold_rx = 1'b1;
    send_item(8'($urandom_range(0, 255)), 8'($urandom_range(20, 40)));
    while (pay_left != '0)
      send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

    for (int p = 0; p < 3; p++) begin
      drain_results();
      write_reg(CFG_DEST_HIGH, $urandom());
      write_reg(CFG_DEST_LOW, $urandom());
      write_reg(CFG_NET_ADDR, $urandom_range(0, 16'hFFFF));
      write_reg(CFG_FRAME_ID, $urandom_range(0, 255));
      write_reg(CFG_RADIUS, $urandom_range(0, 255));
      write_reg(CFG_OPTIONS, $urandom_range(0, 255));
      sent = 0;
      while (sent < 45) begin
        if (pay_left != '0) l = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 19) == 0) l = '0;
        else if ($urandom_range(0, 9) == 0) l = 8'($urandom_range(7, 24));
        else l = 8'($urandom_range(1, 6));
        send_item(8'($urandom_range(0, 255)), l);
        sent++;
      end
    end

    // close the open frame, then a length above the limit; that frame stays open
    while (pay_left != '0)
      send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    send_item(8'($urandom_range(0, 255)), 8'($urandom_range(242, 255)));
    repeat (2) send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && frame_bytes_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : result_sink
    res_t got;
    res_t want;
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 7);
      if (hold_rx) begin
        hold_rx = 1'b0;
        stall = HoldCycles;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.out_byte    = out_ch.out_byte;
      got.last_of_run = out_ch.last_of_run;
      got.frame_end   = out_ch.frame_end;
      if (frame_bytes_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transaction: byte %02h last %0b end %0b",
                   got.out_byte, got.last_of_run, got.frame_end);
        mismatches++;
      end else begin
        want = frame_bytes_q.pop_front();
        if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
            got.frame_end !== want.frame_end) begin
          if (mismatches < 10)
            $display("mismatch: expected byte %02h last %0b end %0b, got byte %02h last %0b end %0b",
                     want.out_byte, want.last_of_run, want.frame_end,
                     got.out_byte, got.last_of_run, got.frame_end);
          mismatches++;
        end
      end
    end
  end

  // stops a hung run: no transaction on either side for too long
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule

>>> files.f
rtl/core/atfb_pkg.sv
rtl/core/atfb_if.sv
rtl/core/atfb_cfg_regs.sv
rtl/core/atfb_seq.sv
rtl/core/api_transmit_frame_builder.sv
sim/tb_top.sv
